FILE: src/wdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV duration parser package
// Shared constants, controller command and status types, tag byte helper.
// ----------------------------------------------------------------------------
package wdp_pkg;

  localparam int LENGTH_BITS = 32;
  localparam logic [31:0] LENGTH_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int MIN_FILE = 44;
  localparam int MS_PER_S = 1000;
  localparam int FMT_MIN  = 16;
  localparam logic [30:0] DUR_MAX = 31'h7FFF_FFFF;

  localparam int NUM_BITS  = 42;
  localparam int DEN_BITS  = 61;
  localparam int STEP_BITS = 6;

  typedef struct packed {
    logic take;
    logic calc_load;
    logic mul_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = tag[31:24];
      2'd1: b = tag[23:16];
      2'd2: b = tag[15:8];
      default: b = tag[7:0];
    endcase
    return b;
  endfunction

endpackage

FILE: src/wdp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV duration parser controller
// Sequences byte intake, operand load, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
module wdp_ctrl import wdp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.take      = in_valid && in_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.calc_load = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/wdp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV duration parser datapath
// Header and chunk walk, length register, multiplier, restoring divider.
// ----------------------------------------------------------------------------
module wdp_datapath import wdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic [7:0]  byte_in,
  input  cmd_t        cmd,
  output status_t     status,
  output logic [30:0] duration_ms,
  output logic        header_ok
);

  logic [31:0] file_length;
  logic [31:0] byte_offset;
  logic [32:0] nco;
  logic [32:0] fmt_body;
  logic [31:0] chunk_tag;
  logic [31:0] chunk_length;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [15:0] sample_bits;
  logic [31:0] data_length;
  logic        magic_ok;
  logic        walk_done;
  logic        fmt_phase;

  logic [32:0] off_ext;
  logic        in_range;
  logic        off_ge_nco;
  logic        fmt_active;
  logic [32:0] hdr_rel;
  logic [32:0] fmt_rel;
  logic [31:0] len_full;
  logic [32:0] hdr_end;
  logic [33:0] chunk_end;
  logic        end_past;
  logic [32:0] nco_next;
  logic [31:0] data_rest;
  logic        ok_now;

  logic                 calc_ok;
  logic [47:0]          prod_rc;
  logic [12:0]          bps_q;
  logic [NUM_BITS-1:0]  num_q;
  logic [DEN_BITS-1:0]  den;
  logic [DEN_BITS-1:0]  rem;
  logic [NUM_BITS-1:0]  quo;
  logic [STEP_BITS-1:0] step_cnt;
  logic [DEN_BITS:0]    trial;
  logic [DEN_BITS:0]    trial_sub;
  logic                 div_ge;

  assign off_ext    = {1'b0, byte_offset};
  assign in_range   = byte_offset < file_length;
  assign off_ge_nco = off_ext >= nco;
  assign fmt_active = fmt_phase && !off_ge_nco;
  assign hdr_rel    = off_ext - nco;
  assign fmt_rel    = off_ext - fmt_body;
  assign len_full   = {byte_in, chunk_length[23:0]};
  assign hdr_end    = nco + 33'd8;
  assign chunk_end  = {1'b0, hdr_end} + {2'b00, len_full};
  assign end_past   = chunk_end > {2'b00, file_length};
  assign nco_next   = chunk_end[32:0] + {32'd0, len_full[0]};
  assign data_rest  = file_length - hdr_end[31:0];

  assign ok_now = (file_length >= 32'(MIN_FILE)) && magic_ok && (byte_offset >= 32'd12) &&
                  (sample_rate != 32'd0) && !sample_rate[31] &&
                  (channel_count != 16'd0) && (sample_bits[15:3] != 13'd0) &&
                  (data_length != 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= 32'd0;
    end else if (cfg_we) begin
      file_length <= cfg_data & LENGTH_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.calc_load) begin
      byte_offset   <= 32'd0;
      nco           <= 33'd12;
      fmt_body      <= 33'd0;
      chunk_tag     <= 32'd0;
      chunk_length  <= 32'd0;
      channel_count <= 16'd0;
      sample_rate   <= 32'd0;
      sample_bits   <= 16'd0;
      data_length   <= 32'd0;
      magic_ok      <= 1'b1;
      walk_done     <= 1'b0;
      fmt_phase     <= 1'b0;
    end else if (cmd.take) begin
      if (byte_offset != '1) byte_offset <= byte_offset + 32'd1;
      if (in_range) begin
        if (byte_offset < 32'd4) begin
          if (byte_in != tag_byte(TAG_RIFF, byte_offset[1:0])) magic_ok <= 1'b0;
        end else if (byte_offset < 32'd12) begin
          if (byte_offset[3] && (byte_in != tag_byte(TAG_WAVE, byte_offset[1:0])))
            magic_ok <= 1'b0;
        end else if (!walk_done) begin
          if (fmt_phase && off_ge_nco) fmt_phase <= 1'b0;
          if (fmt_active) begin
            if (fmt_rel[32:4] == '0) begin
              case (fmt_rel[3:0])
                4'd2:  channel_count[7:0]  <= byte_in;
                4'd3:  channel_count[15:8] <= byte_in;
                4'd4:  sample_rate[7:0]    <= byte_in;
                4'd5:  sample_rate[15:8]   <= byte_in;
                4'd6:  sample_rate[23:16]  <= byte_in;
                4'd7:  sample_rate[31:24]  <= byte_in;
                4'd14: sample_bits[7:0]    <= byte_in;
                4'd15: sample_bits[15:8]   <= byte_in;
                default: ;
              endcase
            end
          end else if (off_ge_nco && (hdr_rel[32:3] == '0)) begin
            if (!hdr_rel[2]) begin
              chunk_tag <= {chunk_tag[23:0], byte_in};
            end else begin
              case (hdr_rel[1:0])
                2'd0: chunk_length <= {24'd0, byte_in};
                2'd1: chunk_length[15:8] <= byte_in;
                2'd2: chunk_length[23:16] <= byte_in;
                default: begin
                  chunk_length[31:24] <= byte_in;
                  if (end_past) begin
                    if (chunk_tag == TAG_DATA) data_length <= data_rest;
                    walk_done <= 1'b1;
                  end else if ((chunk_tag == TAG_FMT) && (len_full >= 32'(FMT_MIN))) begin
                    fmt_phase <= 1'b1;
                    fmt_body  <= hdr_end;
                    nco       <= nco_next;
                  end else if (chunk_tag == TAG_DATA) begin
                    data_length <= len_full;
                    walk_done   <= 1'b1;
                  end else begin
                    nco <= nco_next;
                  end
                end
              endcase
            end
          end
        end
      end
    end
  end

  assign trial     = {rem, quo[NUM_BITS-1]};
  assign div_ge    = trial >= {1'b0, den};
  assign trial_sub = trial - {1'b0, den};

  assign status.div_last = (step_cnt == STEP_BITS'(NUM_BITS - 1));

  always_ff @(posedge clk) begin
    if (cmd.calc_load) begin
      calc_ok <= ok_now;
      prod_rc <= 48'(sample_rate) * 48'(channel_count);
      bps_q   <= sample_bits[15:3];
      num_q   <= NUM_BITS'(data_length) * NUM_BITS'(MS_PER_S);
    end
    if (cmd.mul_load) begin
      den      <= DEN_BITS'(prod_rc) * DEN_BITS'(bps_q);
      rem      <= '0;
      quo      <= num_q;
      step_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem      <= div_ge ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      quo      <= {quo[NUM_BITS-2:0], div_ge};
      step_cnt <= step_cnt + STEP_BITS'(1);
    end
    if (cmd.out_load) begin
      header_ok <= calc_ok;
      if (!calc_ok) begin
        duration_ms <= 31'd0;
      end else if (quo[NUM_BITS-1:31] != '0) begin
        duration_ms <= DUR_MAX;
      end else begin
        duration_ms <= quo[30:0];
      end
    end
  end

endmodule

FILE: src/wav_duration_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV duration parser
// Walks a RIFF/WAVE byte stream and reports the play time in milliseconds.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; after the byte flagged last, intake stops
// until the result is loaded into the output register.
// After the last byte, the result passes through operand load, one
// multiply, 42 steps of the bit-serial divider and output load.
// Reset: synchronous, clears the parse state, length register and output
// valid; the result fields hold their value until the first result.
module wav_duration_parser_top import wdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,       // file_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // duration_ms[30:0], zero pad [31]
  output logic        m_axis_tuser    // header_ok
);

  cmd_t        cmd;
  status_t     status;
  logic [30:0] duration_ms;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {1'b0, duration_ms};

  wdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wdp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .byte_in     (s_axis_tdata),
    .cmd         (cmd),
    .status      (status),
    .duration_ms (duration_ms),
    .header_ok   (m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("item intake continued after last byte");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("failed header with nonzero duration");

  a_result_after_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without calculation");
`endif

endmodule
